/* rtl/nva_pkg.sv */
// Shared types, constants and helper functions for the note-to-voice allocator.
package nva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int VOICE_W    = $clog2(NUM_VOICES);
    localparam int COUNT_W    = 4;
    localparam int NOTE_W     = 7;
    localparam int MODE_W     = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // Chain modes.
    localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RROBIN = 2'd2;

    // Request types.
    localparam logic REQ_ON  = 1'b0;
    localparam logic REQ_OFF = 1'b1;

    // Register indexes, taken from the word address.
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(NUM_VOICES);

    typedef logic [NUM_VOICES-1:0] t_voice_mask;

    // Decision for one request: which voices change and how the pointer moves.
    typedef struct packed {
        t_voice_mask        mask;
        logic               rr_take;
        logic [VOICE_W-1:0] rr_idx;
    } t_pick;

    // Keep only the lowest set bit.
    function automatic t_voice_mask lowest_bit(input t_voice_mask x);
        return x & (~x + t_voice_mask'(1));
    endfunction

    // Keep only the highest set bit.
    function automatic t_voice_mask highest_bit(input t_voice_mask x);
        t_voice_mask rev;
        t_voice_mask sel;
        t_voice_mask res;
        for (int v = 0; v < NUM_VOICES; v++) begin
            rev[v] = x[NUM_VOICES-1-v];
        end
        sel = lowest_bit(rev);
        for (int v = 0; v < NUM_VOICES; v++) begin
            res[v] = sel[NUM_VOICES-1-v];
        end
        return res;
    endfunction

    // Encode a one-hot mask into a voice index.
    function automatic logic [VOICE_W-1:0] mask_to_index(input t_voice_mask x);
        logic [VOICE_W-1:0] idx;
        idx = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (x[v]) begin
                idx = idx | VOICE_W'(v);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/nva_select.sv */
// Voice selection logic: picks the voices that a request assigns or releases.
module nva_select
    import nva_pkg::*;
(
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_req_type,
    input  logic [NOTE_W-1:0]  i_note,
    input  t_voice_mask        i_busy,
    input  logic [NOTE_W-1:0]  i_held_note [NUM_VOICES],
    input  logic [VOICE_W-1:0] i_rr_ptr,
    input  logic               i_rr_valid,
    output t_pick              o_pick
);

    logic [COUNT_W-1:0] active_n;
    logic [COUNT_W-1:0] ptr_ext;
    logic [COUNT_W-1:0] fwd_start;
    logic [COUNT_W-1:0] bwd_start;
    t_voice_mask        in_use;
    t_voice_mask        free_v;
    t_voice_mask        match_v;
    t_voice_mask        fwd_win;
    t_voice_mask        bwd_win;
    t_voice_mask        rr_on_pick;
    t_voice_mask        rr_off_pick;

    // Number of voices in use, saturated into 1..NUM_VOICES.
    always_comb begin
        if (i_count == '0) begin
            active_n = COUNT_W'(1);
        end else if (i_count > COUNT_W'(NUM_VOICES)) begin
            active_n = COUNT_W'(NUM_VOICES);
        end else begin
            active_n = i_count;
        end
    end

    // Round-robin start points for the forward and backward searches.
    assign ptr_ext = COUNT_W'(i_rr_ptr);

    always_comb begin
        if (i_rr_valid && (ptr_ext + COUNT_W'(1) < active_n)) begin
            fwd_start = ptr_ext + COUNT_W'(1);
        end else begin
            fwd_start = '0;
        end
        if ((ptr_ext == '0) || (ptr_ext > active_n)) begin
            bwd_start = active_n - COUNT_W'(1);
        end else begin
            bwd_start = ptr_ext - COUNT_W'(1);
        end
    end

    // Per-voice status compared in parallel.
    always_comb begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            in_use[v]  = COUNT_W'(v) < active_n;
            free_v[v]  = in_use[v] && !i_busy[v];
            match_v[v] = in_use[v] && i_busy[v] && (i_held_note[v] == i_note);
            fwd_win[v] = COUNT_W'(v) >= fwd_start;
            bwd_win[v] = COUNT_W'(v) <= bwd_start;
        end
    end

    // Rotating searches: take the window first, wrap around to the rest.
    always_comb begin
        if ((free_v & fwd_win) != '0) begin
            rr_on_pick = lowest_bit(free_v & fwd_win);
        end else begin
            rr_on_pick = lowest_bit(free_v);
        end
        if ((match_v & bwd_win) != '0) begin
            rr_off_pick = highest_bit(match_v & bwd_win);
        end else begin
            rr_off_pick = highest_bit(match_v);
        end
    end

    // Mode selection.
    always_comb begin
        o_pick = '0;
        case (i_mode)
            MODE_DIRECT: begin
                o_pick.mask = (i_req_type == REQ_OFF) ? match_v : free_v;
            end
            MODE_FIRST: begin
                o_pick.mask = (i_req_type == REQ_OFF) ? lowest_bit(match_v)
                                                      : lowest_bit(free_v);
            end
            MODE_RROBIN: begin
                if (i_req_type == REQ_ON) begin
                    o_pick.mask    = rr_on_pick;
                    o_pick.rr_take = rr_on_pick != '0;
                    o_pick.rr_idx  = mask_to_index(rr_on_pick);
                end else if (i_rr_valid) begin
                    o_pick.mask = rr_off_pick;
                end
            end
            default: begin
                o_pick = '0;
            end
        endcase
    end

endmodule

/* rtl/note_to_voice_allocator_unit.sv */
// Top level of the note-to-voice allocator with its register port and voice state.
// Throughput: one request per cycle while the result channel is not stalled; the input register
// feeds the voice compare logic and the result register, and the voice state is updated when
// the result is registered.
// Reset (synchronous, active low): all voices free, round-robin pointer cleared and
// invalid, chain_mode 0 and voice_count 8, both pipeline registers empty.
module note_to_voice_allocator_unit
    import nva_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel.
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    input  logic [NOTE_W-1:0] i_note,
    // Result channel.
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_affected_voices,
    output logic              o_found,
    // Register port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [MODE_W-1:0]  r_mode;
    logic [COUNT_W-1:0] r_count;
    logic               cfg_wr;

    logic               r_in_valid;
    logic               r_in_type;
    logic [NOTE_W-1:0]  r_in_note;
    logic               r_out_valid;
    logic [7:0]         r_aff;
    logic               r_found;

    t_voice_mask        r_busy;
    t_voice_mask        n_busy;
    logic [NOTE_W-1:0]  r_held_note [NUM_VOICES];
    logic [VOICE_W-1:0] r_rr_ptr;
    logic               r_rr_valid;

    logic               in_accept;
    logic               out_free;
    logic               advance;
    t_pick              pick;

    // Register port: always ready, decoded on the word address.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_COUNT) ? APB_DW'(r_count) : APB_DW'(r_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DIRECT;
            r_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_COUNT) begin
                r_count <= pwdata[COUNT_W-1:0];
            end else begin
                r_mode <= pwdata[MODE_W-1:0];
            end
        end
    end

    // Pipeline flow control.
    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_type <= i_req_type;
            r_in_note <= i_note;
        end
    end

    // Voice selection for the registered request.
    nva_select u_select (
        .i_mode      (r_mode),
        .i_count     (r_count),
        .i_req_type  (r_in_type),
        .i_note      (r_in_note),
        .i_busy      (r_busy),
        .i_held_note (r_held_note),
        .i_rr_ptr    (r_rr_ptr),
        .i_rr_valid  (r_rr_valid),
        .o_pick      (pick)
    );

    // Busy flags after the request: set on assign, cleared on release.
    assign n_busy = (r_in_type == REQ_OFF) ? (r_busy & ~pick.mask) : (r_busy | pick.mask);

    // Voice state update as the request moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= '0;
            r_rr_ptr   <= '0;
            r_rr_valid <= 1'b0;
        end else if (advance) begin
            r_busy <= n_busy;
            if (pick.rr_take) begin
                r_rr_ptr   <= pick.rr_idx;
                r_rr_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (advance && (r_in_type == REQ_ON) && pick.mask[v]) begin
                r_held_note[v] <= r_in_note;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_aff   <= 8'(pick.mask);
            r_found <= pick.mask != '0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_affected_voices = r_aff;
    assign o_found           = r_found;

endmodule

/* sim/tb_note_to_voice_allocator_unit.sv */
// Self-checking testbench for the note-to-voice allocator: directed and random requests.
module tb_note_to_voice_allocator_unit;
    import nva_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int RANDOM_PHASES = 10;

    typedef struct packed {
        logic              req_kind;
        logic [NOTE_W-1:0] note;
    } note_req_t;

    typedef struct packed {
        t_voice_mask voices;
        logic        found;
    } voice_change_t;

    // Clock, reset and block ports.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_req_type = REQ_ON;
    logic [NOTE_W-1:0] i_note = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [7:0]        o_affected_voices;
    logic              o_found;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Predicted voice state and configuration.
    logic [NOTE_W-1:0]  voice_note [NUM_VOICES];
    logic               voice_on [NUM_VOICES];
    int                 last_voice;
    logic               last_voice_ok;
    logic [MODE_W-1:0]  alloc_mode;
    logic [COUNT_W-1:0] alloc_count;

    // Request and result bookkeeping.
    note_req_t         note_reqs_pending [$];
    voice_change_t     voice_changes_due [$];
    logic [NOTE_W-1:0] notes_sounding [$];
    logic              req_taken = 1'b0;
    int                mismatches = 0;
    int                idle_cycles = 0;
    int                send_gap_pct = 0;
    int                stall_pct = 0;
    int                hold_off_left = 0;

    // Settings for the random phases.
    logic [MODE_W-1:0]  phase_mode [RANDOM_PHASES] = '{MODE_RROBIN, MODE_FIRST, MODE_DIRECT,
        MODE_RROBIN, MODE_RROBIN, MODE_FIRST, MODE_RROBIN, MODE_UNUSED, MODE_DIRECT, MODE_RROBIN};
    logic [COUNT_W-1:0] phase_count [RANDOM_PHASES] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd8, 4'd0,
        4'd5, 4'd8, 4'd12, 4'd2};

    note_to_voice_allocator_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_note            (i_note),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_affected_voices (o_affected_voices),
        .o_found           (o_found),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Work out which voices one request takes or frees, and update the predicted state.
    function automatic voice_change_t allocate_voices(input logic req_kind,
                                                      input logic [NOTE_W-1:0] note);
        voice_change_t chg;
        int n;
        int v;
        int k;
        logic done;
        chg.voices = '0;
        done = 1'b0;
        n = (alloc_count == 0) ? 1 :
            ((alloc_count > NUM_VOICES) ? NUM_VOICES : int'(alloc_count));
        if (alloc_mode == MODE_DIRECT || alloc_mode == MODE_FIRST) begin
            // Scan upward; first-available stops at the first voice that changes.
            for (v = 0; v < n && !done; v++) begin
                if (req_kind == REQ_ON && !voice_on[v]) begin
                    voice_note[v] = note;
                    voice_on[v] = 1'b1;
                    chg.voices[v] = 1'b1;
                    done = (alloc_mode == MODE_FIRST);
                end else if (req_kind == REQ_OFF && voice_on[v] && voice_note[v] == note) begin
                    voice_on[v] = 1'b0;
                    chg.voices[v] = 1'b1;
                    done = (alloc_mode == MODE_FIRST);
                end
            end
        end else if (alloc_mode == MODE_RROBIN && req_kind == REQ_ON) begin
            // Forward search from the voice after the last one taken, wrapping once.
            v = (last_voice_ok && last_voice + 1 < n) ? last_voice + 1 : 0;
            for (k = 0; k < n && !done; k++) begin
                if (!voice_on[v]) begin
                    voice_note[v] = note;
                    voice_on[v] = 1'b1;
                    chg.voices[v] = 1'b1;
                    last_voice = v;
                    last_voice_ok = 1'b1;
                    done = 1'b1;
                end else begin
                    v = (v + 1 < n) ? v + 1 : 0;
                end
            end
        end else if (alloc_mode == MODE_RROBIN && last_voice_ok) begin
            // Backward search from the voice before the pointer, or from the top voice
            // in use when the pointer is zero or lies past the count.
            v = (last_voice == 0 || last_voice > n) ? n - 1 : last_voice - 1;
            for (k = 0; k < n && !done; k++) begin
                if (voice_on[v] && voice_note[v] == note) begin
                    voice_on[v] = 1'b0;
                    chg.voices[v] = 1'b1;
                    done = 1'b1;
                end else begin
                    v = (v == 0) ? n - 1 : v - 1;
                end
            end
        end
        chg.found = |chg.voices;
        return chg;
    endfunction

    // Result check, request capture and watchdog, all sampled at the rising edge.
    always @(posedge i_clk) begin : result_check
        voice_change_t due;
        voice_change_t pred;
        if (i_rst_n && o_valid && !i_stall) begin
            if (voice_changes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: voices %h found %b",
                             o_affected_voices, o_found);
                end
            end else begin
                due = voice_changes_due.pop_front();
                if (o_affected_voices !== due.voices || o_found !== due.found) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected voices %h found %b, got %h found %b",
                                 due.voices, due.found, o_affected_voices, o_found);
                    end
                end
            end
        end
        req_taken = i_rst_n && i_valid && !o_stall;
        if (req_taken) begin
            pred = allocate_voices(i_req_type, i_note);
            voice_changes_due.push_back(pred);
        end
        if (req_taken || (i_rst_n && o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_note_to_voice_allocator_unit: done, errors");
            $finish;
        end
    end

    // Request driver: a new beat is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        if (req_taken) begin
            void'(note_reqs_pending.pop_front());
        end
        if (!i_valid || req_taken) begin
            if (note_reqs_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                i_valid    <= 1'b1;
                i_req_type <= note_reqs_pending[0].req_kind;
                i_note     <= note_reqs_pending[0].note;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure, with an optional long hold-off counted down here.
    always @(negedge i_clk) begin
        if (hold_off_left != 0) begin
            i_stall <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Register write over the APB port, mirrored into the predicted configuration.
    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_MODE) begin
            alloc_mode = value[MODE_W-1:0];
        end else begin
            alloc_count = value[COUNT_W-1:0];
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic add_req(input logic req_kind, input logic [NOTE_W-1:0] note);
        note_req_t req;
        req.req_kind = req_kind;
        req.note = note;
        note_reqs_pending.push_back(req);
    endtask

    // Wait until every request went in and every result came back.
    task automatic drain_results();
        while (note_reqs_pending.size() != 0 || voice_changes_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idling(input int profile);
        case (profile)
            0: begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            1: begin
                send_gap_pct = 61;
                stall_pct = 0;
            end
            2: begin
                send_gap_pct = 0;
                stall_pct = 61;
            end
            default: begin
                send_gap_pct = 31;
                stall_pct = 31;
            end
        endcase
    endtask

    // Mostly note-on followed later by the matching note-off, plus some stray requests.
    task automatic queue_random_notes(input int count);
        note_req_t req;
        int roll;
        int k;
        int i;
        for (i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                req.req_kind = ($urandom_range(1) != 0);
                req.note = NOTE_W'($urandom_range(127));
            end else if (roll < 50 && notes_sounding.size() != 0) begin
                k = $urandom_range(notes_sounding.size() - 1);
                req.req_kind = REQ_OFF;
                req.note = notes_sounding[k];
                notes_sounding.delete(k);
            end else begin
                req.req_kind = REQ_ON;
                // A small pool of low notes makes several voices hold the same note.
                req.note = ($urandom_range(3) == 0) ? NOTE_W'($urandom_range(3)) :
                           NOTE_W'($urandom_range(127));
                notes_sounding.push_back(req.note);
                if (notes_sounding.size() > 16) begin
                    void'(notes_sounding.pop_front());
                end
            end
            note_reqs_pending.push_back(req);
        end
    endtask

    initial begin : stimulus
        int p;
        int v;
        int n_items;
        for (v = 0; v < NUM_VOICES; v++) begin
            voice_note[v] = '0;
            voice_on[v] = 1'b0;
        end
        last_voice = 0;
        last_voice_ok = 1'b0;
        alloc_mode = MODE_DIRECT;
        alloc_count = COUNT_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        set_idling(0);

        // Direct mode from reset: free voices holding note 0 must not match a clear.
        add_req(REQ_OFF, 7'd0);
        add_req(REQ_ON, 7'd0);
        add_req(REQ_ON, 7'd127);
        add_req(REQ_OFF, 7'd127);
        add_req(REQ_OFF, 7'd0);
        drain_results();

        // First-available: lowest free voice, lowest matching voice.
        write_reg(REG_MODE, {30'($urandom), MODE_FIRST});
        add_req(REQ_ON, 7'd85);
        add_req(REQ_ON, 7'd42);
        add_req(REQ_ON, 7'd85);
        add_req(REQ_OFF, 7'd85);
        add_req(REQ_OFF, 7'd85);
        add_req(REQ_OFF, 7'd42);
        drain_results();

        // Round-robin on one voice: clear before any assign, then a full chain.
        write_reg(REG_MODE, {30'($urandom), MODE_RROBIN});
        write_reg(REG_COUNT, {28'($urandom), 4'd1});
        add_req(REQ_OFF, 7'd9);
        add_req(REQ_ON, 7'd9);
        add_req(REQ_ON, 7'd10);
        add_req(REQ_OFF, 7'd9);
        drain_results();

        // A count above the chain length saturates; move the pointer up.
        write_reg(REG_COUNT, {28'($urandom), 4'd15});
        add_req(REQ_ON, 7'd20);
        add_req(REQ_ON, 7'd21);
        drain_results();

        // Count zero acts as one voice, with the pointer now past the count.
        write_reg(REG_COUNT, {28'($urandom), 4'd0});
        add_req(REQ_OFF, 7'd21);
        add_req(REQ_ON, 7'd22);
        add_req(REQ_OFF, 7'd22);
        drain_results();

        // The unused mode changes nothing.
        write_reg(REG_MODE, {30'($urandom), MODE_UNUSED});
        write_reg(REG_COUNT, {28'($urandom), 4'd8});
        add_req(REQ_ON, 7'd5);
        add_req(REQ_OFF, 7'd20);
        drain_results();

        // Random phases across modes, counts and idling profiles.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(REG_MODE, {30'($urandom), phase_mode[p]});
            write_reg(REG_COUNT, {28'($urandom), phase_count[p]});
            set_idling(p % 4);
            n_items = (phase_mode[p] == MODE_UNUSED) ? 30 : 60;
            if (p == 4) begin
                // Hold results back while requests keep coming, so the input stalls.
                set_idling(0);
                @(posedge i_clk);
                hold_off_left = HOLD_OFF_LEN;
            end
            queue_random_notes(n_items / 2);
            if (p == 6) begin
                // Sender pauses until every outstanding result has come back.
                drain_results();
            end
            queue_random_notes(n_items - n_items / 2);
            drain_results();
        end

        if (mismatches == 0) begin
            $display("tb_note_to_voice_allocator_unit: done, clean");
        end else begin
            $display("tb_note_to_voice_allocator_unit: done, errors");
        end
        $finish;
    end

endmodule
